// ===== design/fpalu_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared constants, opcode names, pipeline stage types and the divider step
// for the signed fixed-point ALU.
// ----------------------------------------------------------------------------
package fpalu_pkg;

   // Number of fraction bits of the operands (range 1 to 30).
   localparam int FRAC_BITS = 8;

   // Width of the operands and results.
   localparam int WORD_W = 32;

   // Dividend |a| << FRAC_BITS, padded to an even width for two steps a stage.
   localparam int DIVIDEND_W = WORD_W + FRAC_BITS;
   localparam int DIV_W      = DIVIDEND_W + (DIVIDEND_W % 2);
   localparam int DIV_STAGES = DIV_W / 2;

   // Packed channel widths, filled up to whole bytes.
   localparam int REQ_BITS = 4 + 2 * WORD_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = WORD_W + 2;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef logic [3:0]        opcode_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [DIV_W-1:0]  dividend_type;

   // Operation codes.
   localparam opcode_type OP_ADD     = 4'd0;
   localparam opcode_type OP_SUB     = 4'd1;
   localparam opcode_type OP_MUL     = 4'd2;
   localparam opcode_type OP_DIV     = 4'd3;
   localparam opcode_type OP_LT      = 4'd4;
   localparam opcode_type OP_GT      = 4'd5;
   localparam opcode_type OP_LE      = 4'd6;
   localparam opcode_type OP_GE      = 4'd7;
   localparam opcode_type OP_EQ      = 4'd8;
   localparam opcode_type OP_NE      = 4'd9;
   localparam opcode_type OP_MIN     = 4'd10;
   localparam opcode_type OP_MAX     = 4'd11;
   localparam opcode_type OP_INC     = 4'd12;
   localparam opcode_type OP_DEC     = 4'd13;
   localparam opcode_type OP_FROMINT = 4'd14;
   localparam opcode_type OP_TOINT   = 4'd15;

   // Input register stage.
   typedef struct packed {
      logic       valid;
      opcode_type op;
      word_type   a;
      word_type   b;
   } in_stage_type;

   // Decode and divider stages. The dividend register shifts quotient bits in
   // from the bottom while the dividend bits leave at the top.
   typedef struct packed {
      logic         valid;
      opcode_type   op;
      logic         neg;
      logic         dz;
      logic         cmp;
      word_type     result;
      word_type     divisor;
      word_type     rem;
      dividend_type dq;
   } div_stage_type;

   // Finished result.
   typedef struct packed {
      word_type result;
      logic     cmp;
      logic     dz;
   } result_type;

   typedef struct packed {
      word_type     rem;
      dividend_type dq;
   } div_state_type;

   // One restoring division step: bring down the next dividend bit, subtract
   // the divisor when it fits and record the quotient bit.
   function automatic div_state_type div_step(div_state_type cur, word_type divisor);
      logic [WORD_W:0] trial;
      logic [WORD_W:0] diff;
      logic            fits;
      div_state_type   nxt;
      trial   = {cur.rem, cur.dq[DIV_W-1]};
      diff    = trial - {1'b0, divisor};
      fits    = (trial >= {1'b0, divisor});
      nxt.rem = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      nxt.dq  = {cur.dq[DIV_W-2:0], fits};
      return nxt;
   endfunction

endpackage

// ===== design/fixed_point_alu_unit.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU unit
// Signed Q(31-F).F arithmetic, comparisons and conversions in a fully
// pipelined datapath with a restoring divider of two bits per stage.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+------------------------------------
//   req     | in        | req_tvalid/req_tready  | opcode, operand_a, operand_b
//   rsp     | out       | rsp_tvalid/rsp_tready  | result_value, compare_true, divide_by_zero
//
// One item enters per cycle while the skid register is empty. Each item passes
// through the input register, decode, DIV_STAGES divider stages of two
// quotient bits each, the sign fix-up stage and the output register. The
// divider stage count sets the latency; every opcode takes the same path so
// results stay in order. Reset clears all valid bits. A stalled output fills a
// one-item skid register, and the pipeline holds only once that is full.

module fixed_point_alu_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [3:0] opcode, [35:4] operand_a, [67:36] operand_b, rest zero.
   input  logic [fpalu_pkg::REQ_W-1:0]    req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] result_value, [32] compare_true, [33] divide_by_zero, rest zero.
   output logic [fpalu_pkg::RSP_W-1:0]    rsp_tdata
);

   localparam int F = fpalu_pkg::FRAC_BITS;
   localparam int W = fpalu_pkg::WORD_W;

   // Global advance of the pipeline; it stops only while the skid stage holds an item.
   logic en;

   fpalu_pkg::in_stage_type  s0_ff, s0_in;
   fpalu_pkg::div_stage_type s1_ff, s1_in;
   fpalu_pkg::div_stage_type div_ff [fpalu_pkg::DIV_STAGES];
   fpalu_pkg::div_stage_type div_in [fpalu_pkg::DIV_STAGES];
   logic [2*W-1:0]           prod_ff, prod_in;
   logic                     fin_valid_ff, fin_valid_in;
   fpalu_pkg::result_type    fin_ff, fin_in;
   logic                     out_valid_ff, out_valid_in;
   fpalu_pkg::result_type    out_ff, out_in;
   logic                     skid_valid_ff, skid_valid_in;
   fpalu_pkg::result_type    skid_ff, skid_in;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // Input register.
   always_comb begin
      s0_in.valid = req_tvalid;
      s0_in.op    = req_tdata[3:0];
      s0_in.a     = req_tdata[4 +: W];
      s0_in.b     = req_tdata[4 + W +: W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else if (en) begin
         s0_ff <= s0_in;
      end
   end

   // Decode: magnitudes and signs, and the results of all operations but multiply and divide.
   always_comb begin
      logic signed [W-1:0] sa;
      logic signed [W-1:0] sb;
      logic                lt;
      logic                gt;
      fpalu_pkg::word_type mag_a;
      fpalu_pkg::word_type mag_b;
      sa    = s0_ff.a;
      sb    = s0_ff.b;
      lt    = (sa < sb);
      gt    = (sa > sb);
      mag_a = s0_ff.a[W-1] ? (~s0_ff.a + 1'b1) : s0_ff.a;
      mag_b = s0_ff.b[W-1] ? (~s0_ff.b + 1'b1) : s0_ff.b;

      s1_in.valid   = s0_ff.valid;
      s1_in.op      = s0_ff.op;
      s1_in.neg     = s0_ff.a[W-1] ^ s0_ff.b[W-1];
      s1_in.dz      = (s0_ff.op == fpalu_pkg::OP_DIV) && (s0_ff.b == '0);
      s1_in.cmp     = 1'b0;
      s1_in.result  = '0;
      s1_in.divisor = mag_b;
      s1_in.rem     = '0;
      s1_in.dq      = fpalu_pkg::dividend_type'(mag_a) << F;

      unique case (s0_ff.op)
         fpalu_pkg::OP_ADD:     s1_in.result = s0_ff.a + s0_ff.b;
         fpalu_pkg::OP_SUB:     s1_in.result = s0_ff.a - s0_ff.b;
         fpalu_pkg::OP_LT:      s1_in.cmp = lt;
         fpalu_pkg::OP_GT:      s1_in.cmp = gt;
         fpalu_pkg::OP_LE:      s1_in.cmp = !gt;
         fpalu_pkg::OP_GE:      s1_in.cmp = !lt;
         fpalu_pkg::OP_EQ:      s1_in.cmp = (s0_ff.a == s0_ff.b);
         fpalu_pkg::OP_NE:      s1_in.cmp = (s0_ff.a != s0_ff.b);
         fpalu_pkg::OP_MIN:     s1_in.result = lt ? s0_ff.a : s0_ff.b;
         fpalu_pkg::OP_MAX:     s1_in.result = gt ? s0_ff.a : s0_ff.b;
         fpalu_pkg::OP_INC:     s1_in.result = s0_ff.a + 1'b1;
         fpalu_pkg::OP_DEC:     s1_in.result = s0_ff.a - 1'b1;
         fpalu_pkg::OP_FROMINT: s1_in.result = s0_ff.a << F;
         fpalu_pkg::OP_TOINT:   s1_in.result = fpalu_pkg::word_type'(sa >>> F);
         default:               s1_in.result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ff <= s1_in;
      end
   end

   // Magnitude product, registered alongside the first divider stage.
   assign prod_in = s1_ff.dq[F +: W] * s1_ff.divisor;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   // Divider stages, two quotient bits each. The second stage also applies the
   // sign to the product and takes the scaled middle word.
   for (genvar k = 0; k < fpalu_pkg::DIV_STAGES; k++) begin : g_div
      fpalu_pkg::div_stage_type src;

      if (k == 0) begin : g_first
         assign src = s1_ff;
      end else begin : g_rest
         assign src = div_ff[k-1];
      end

      always_comb begin
         fpalu_pkg::div_state_type st;
         logic [2*W-1:0]           sprod;
         st.rem    = src.rem;
         st.dq     = src.dq;
         st        = fpalu_pkg::div_step(st, src.divisor);
         st        = fpalu_pkg::div_step(st, src.divisor);
         sprod     = src.neg ? (~prod_ff + 1'b1) : prod_ff;
         div_in[k]     = src;
         div_in[k].rem = st.rem;
         div_in[k].dq  = st.dq;
         if (k == 1 && src.op == fpalu_pkg::OP_MUL) begin
            div_in[k].result = sprod[F +: W];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k].valid <= 1'b0;
         end else if (en) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // Sign fix-up of the quotient; division by zero gives zero.
   always_comb begin
      fpalu_pkg::div_stage_type last;
      fpalu_pkg::word_type      quo;
      last         = div_ff[fpalu_pkg::DIV_STAGES-1];
      quo          = last.dq[W-1:0];
      fin_valid_in = last.valid;
      fin_in.cmp   = last.cmp;
      fin_in.dz    = last.dz;
      fin_in.result = last.result;
      if (last.op == fpalu_pkg::OP_DIV) begin
         fin_in.result = last.dz ? '0 : (last.neg ? (~quo + 1'b1) : quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff <= fin_in;
      end
   end

   // Output register with a one-item skid stage behind it.
   always_comb begin
      logic push;
      logic pop;
      push          = en && fin_valid_ff;
      pop           = out_valid_ff && rsp_tready;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = fin_ff;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = fin_ff;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(fpalu_pkg::RSP_W - fpalu_pkg::RSP_BITS){1'b0}},
                        out_ff.dz, out_ff.cmp, out_ff.result};

   // The skid stage only fills behind a waiting output item.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds an item while the output register is empty");

   // A division by zero always leaves a zero result.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && fin_ff.dz) |-> (fin_ff.result == '0))
      else $error("divide-by-zero item carries a nonzero result");

   // A comparison and a division flag never come together.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.cmp && out_ff.dz))
      else $error("compare and divide-by-zero flags both set");

   // An accepted item occupies the input register on the next cycle.
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s0_ff.valid)
      else $error("accepted item missing from the input register");

endmodule
